// ===== rtl/rsi_pkg.sv =====
// Shared constants and types for the relative strength index block.
`timescale 1ns / 1ps

package rsi_pkg;

	// Default sizing of the top level
	localparam int DEF_MAX_WINDOW = 64;
	localparam int DEF_PRICE_BITS = 32;

	// Window register
	localparam int CFG_W         = 7;
	localparam int WINDOW_RESET  = 14;

	// Result scaling: hundredths of a percent
	localparam int QUO_W         = 14;
	localparam int CNT_W         = $clog2(QUO_W);
	localparam logic [QUO_W-1:0] RSI_SCALE   = QUO_W'(10000);
	localparam logic [QUO_W-1:0] RSI_NEUTRAL = QUO_W'(5000);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ACCUM,
		ST_DROP,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} rsi_state_t;

endpackage

// ===== rtl/rsi_hist_mem.sv =====
// Price history ring memory: one write port, one registered read port.
`timescale 1ns / 1ps

module rsi_hist_mem #(
	parameter int DEPTH  = rsi_pkg::DEF_MAX_WINDOW + 1,
	parameter int DATA_W = rsi_pkg::DEF_PRICE_BITS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write the new sample
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read: rdata follows raddr in the next cycle
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/rsi_div.sv =====
// Restoring divider giving one quotient bit per cycle for the scaled ratio.
`timescale 1ns / 1ps

module rsi_div #(
	parameter int SUM_W = rsi_pkg::DEF_PRICE_BITS + $clog2(rsi_pkg::DEF_MAX_WINDOW)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [SUM_W+rsi_pkg::QUO_W-1:0] dividend,
	input  logic [SUM_W-1:0]               divisor,
	output logic                           done,
	output logic [rsi_pkg::QUO_W-1:0]      quotient
);

	localparam int QW = rsi_pkg::QUO_W;
	localparam int CW = rsi_pkg::CNT_W;

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [QW-1:0]    sh_q;
	logic [SUM_W-1:0] div_q;
	logic [SUM_W:0]   trial;
	logic [SUM_W:0]   diff;
	logic             ge;

	// Trial subtract of the shifted remainder
	assign trial = {rem_q, sh_q[QW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = sh_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Load the operands, then shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W+QW-1:QW];
			sh_q  <= dividend[QW-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			sh_q  <= {sh_q[QW-2:0], ge};
		end
	end

endmodule

// ===== rtl/relative_strength_index.sv =====
// Relative strength index over a sliding window of price moves, top level.
`timescale 1ns / 1ps

// Each price beat yields one result beat: the relative strength index of the
// last window_length price moves in hundredths of a percent (0 to 10000),
// floored, or 5000 with warming_up set until window_length+1 samples have been
// seen. Once the window is full and the move sums are not both zero, a sample
// goes from acceptance through history reads and sum updates over the single
// read port of the price memory, then through the restoring divider (one
// quotient bit per step), and then to the output register. While warming up,
// or when both sums are zero, the divider is skipped. A stalled result holds
// the block in its done state until the output register is free, and no new
// sample is accepted before the result is handed on. The history memory needs
// no clearing pass: only entries written since the last clear are read.
// Writing cfg_wdata sets the window (0 reads as 1, larger than MAX_WINDOW as
// MAX_WINDOW) and clears the history and sums; write only while idle.
module relative_strength_index #(
	parameter int MAX_WINDOW = rsi_pkg::DEF_MAX_WINDOW,
	parameter int PRICE_BITS = rsi_pkg::DEF_PRICE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rsi_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [PRICE_BITS-1:0]        price,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rsi_pkg::QUO_W-1:0]    rsi_hundredths,
	output logic                         warming_up
);

	localparam int DEPTH  = MAX_WINDOW + 1;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int SEEN_W = PTR_W + 1;
	localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
	localparam int QW     = rsi_pkg::QUO_W;
	localparam int WIN_RST = (rsi_pkg::WINDOW_RESET > MAX_WINDOW) ?
		MAX_WINDOW : rsi_pkg::WINDOW_RESET;

	rsi_pkg::rsi_state_t state_q, state_d;

	logic [PTR_W-1:0]      len_q;
	logic [PTR_W-1:0]      wp_q;
	logic [SEEN_W-1:0]     seen_q;
	logic [SUM_W-1:0]      up_q, down_q;
	logic [PRICE_BITS-1:0] p_q, prev_q, older_q;
	logic [PRICE_BITS-1:0] new_mag_q, old_mag_q;
	logic                  new_up_q, old_up_q;
	logic                  neutral_q, warm_q;
	logic                  out_valid_q;
	logic [QW-1:0]         rsi_q;

	logic [PTR_W-1:0]      cfg_len;
	logic [SEEN_W-1:0]     len_ext;
	logic                  full_now;
	logic                  in_accept;
	logic                  out_free;
	logic [PTR_W-1:0]      older_addr, newer_addr, rd_addr;
	logic                  sel_newer;
	logic                  mem_we;
	logic [PRICE_BITS-1:0] rd_data;
	logic                  div_start, div_done;
	logic [SUM_W+QW-1:0]   dividend;
	logic [SUM_W-1:0]      divisor;
	logic [QW-1:0]         quotient;
	logic                  out_load;

	// Ring slot holding the sample 'age' steps behind the write pointer
	function automatic logic [PTR_W-1:0] slot_back(
		input logic [PTR_W-1:0]  wp,
		input logic [SEEN_W-1:0] age
	);
		logic [SEEN_W-1:0] tmp;
		tmp = {1'b0, wp} + SEEN_W'(DEPTH) - age;
		if (tmp >= SEEN_W'(DEPTH)) begin
			tmp = tmp - SEEN_W'(DEPTH);
		end
		return tmp[PTR_W-1:0];
	endfunction

	// Clamp the written window length
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_len = PTR_W'(1);
		end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
			cfg_len = PTR_W'(MAX_WINDOW);
		end else begin
			cfg_len = PTR_W'(cfg_wdata);
		end
	end

	assign len_ext    = {1'b0, len_q};
	assign full_now   = (seen_q > len_ext);
	assign older_addr = slot_back(wp_q, len_ext + SEEN_W'(1));
	assign newer_addr = slot_back(wp_q, len_ext);
	assign rd_addr    = sel_newer ? newer_addr : older_addr;
	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign dividend   = (SUM_W+QW)'(up_q) * (SUM_W+QW)'(rsi_pkg::RSI_SCALE);
	assign divisor    = up_q + down_q;

	rsi_hist_mem #(
		.DEPTH  (DEPTH),
		.DATA_W (PRICE_BITS),
		.ADDR_W (PTR_W)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (p_q),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rsi_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsi_pkg::ST_IDLE:  if (in_accept) state_d = rsi_pkg::ST_FETCH;
			rsi_pkg::ST_FETCH: state_d = rsi_pkg::ST_ACCUM;
			rsi_pkg::ST_ACCUM: state_d = rsi_pkg::ST_DROP;
			rsi_pkg::ST_DROP:  state_d = rsi_pkg::ST_LOAD;
			rsi_pkg::ST_LOAD: begin
				if (!full_now || (up_q == '0 && down_q == '0)) begin
					state_d = rsi_pkg::ST_DONE;
				end else begin
					state_d = rsi_pkg::ST_DIV;
				end
			end
			rsi_pkg::ST_DIV:   if (div_done) state_d = rsi_pkg::ST_DONE;
			rsi_pkg::ST_DONE:  if (out_free) state_d = rsi_pkg::ST_IDLE;
			default:           state_d = rsi_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_stall  = 1'b1;
		sel_newer = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			rsi_pkg::ST_IDLE:  in_stall  = 1'b0;
			rsi_pkg::ST_FETCH: sel_newer = 1'b1;
			rsi_pkg::ST_DROP:  mem_we    = 1'b1;
			rsi_pkg::ST_LOAD:  div_start = full_now && !(up_q == '0 && down_q == '0);
			rsi_pkg::ST_DONE:  out_load  = out_free;
			default:           in_stall  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window, pointers and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= PTR_W'(WIN_RST);
			wp_q   <= '0;
			seen_q <= '0;
			up_q   <= '0;
			down_q <= '0;
		end else if (cfg_we) begin
			len_q  <= cfg_len;
			wp_q   <= '0;
			seen_q <= '0;
			up_q   <= '0;
			down_q <= '0;
		end else begin
			case (state_q)
				rsi_pkg::ST_ACCUM: begin
					if (seen_q != '0) begin
						if (new_up_q) begin
							up_q <= up_q + SUM_W'(new_mag_q);
						end else begin
							down_q <= down_q + SUM_W'(new_mag_q);
						end
					end
				end
				rsi_pkg::ST_DROP: begin
					if (full_now) begin
						if (old_up_q) begin
							up_q <= up_q - SUM_W'(old_mag_q);
						end else begin
							down_q <= down_q - SUM_W'(old_mag_q);
						end
					end else begin
						seen_q <= seen_q + SEEN_W'(1);
					end
					if (32'(wp_q) == DEPTH - 1) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_q + PTR_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Sample and move magnitudes
	always_ff @(posedge clk) begin
		if (in_accept) begin
			p_q <= price;
		end
		case (state_q)
			rsi_pkg::ST_FETCH: begin
				older_q   <= rd_data;
				new_up_q  <= (p_q > prev_q);
				new_mag_q <= (p_q > prev_q) ? (p_q - prev_q) : (prev_q - p_q);
			end
			rsi_pkg::ST_ACCUM: begin
				old_up_q  <= (rd_data > older_q);
				old_mag_q <= (rd_data > older_q) ? (rd_data - older_q) : (older_q - rd_data);
			end
			rsi_pkg::ST_DROP: begin
				prev_q <= p_q;
			end
			rsi_pkg::ST_LOAD: begin
				warm_q    <= !full_now;
				neutral_q <= !full_now || (up_q == '0 && down_q == '0);
			end
			default: begin
			end
		endcase
	end

	// Output register: load a finished beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsi_q      <= neutral_q ? rsi_pkg::RSI_NEUTRAL : quotient;
			warming_up <= warm_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign rsi_hundredths = rsi_q;

endmodule

// ===== test/tb.sv =====
// Testbench for the relative strength index block: queued stimulus, clocked driver and monitor.
`timescale 1ns / 1ps

module tb;

	localparam int HIST_SLOTS = rsi_pkg::DEF_MAX_WINDOW + 1;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 240;
	localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

	typedef struct {
		bit                         is_cfg;
		logic [rsi_pkg::CFG_W-1:0]  win;
		logic [31:0]                px;
	} stim_beat_t;

	typedef struct packed {
		logic [rsi_pkg::QUO_W-1:0] rsi;
		logic                      warm;
	} rsi_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rsi_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] price = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [rsi_pkg::QUO_W-1:0] rsi_hundredths;
	logic warming_up;

	stim_beat_t stim_q[$];
	rsi_beat_t rsi_due[$];

	// predictor state
	logic [31:0] hist_mem [0:HIST_SLOTS-1];
	logic [37:0] up_total = '0;
	logic [37:0] down_total = '0;
	int seen_cnt = 0;
	int slot_next = 0;
	int win_len = rsi_pkg::WINDOW_RESET;

	int errors = 0;
	int prices_in = 0;
	int results_seen = 0;
	int n_writes = 0;
	int n_warm = 0;
	int n_flat = 0;
	int n_ratio = 0;
	int settle = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cyc = 0;
	wire steady = (cyc >= 8000) && (cyc < 14000);

	relative_strength_index DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.price          (price),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rsi_hundredths (rsi_hundredths),
		.warming_up     (warming_up)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic int clamp_window(input logic [rsi_pkg::CFG_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > rsi_pkg::DEF_MAX_WINDOW)
			return rsi_pkg::DEF_MAX_WINDOW;
		return int'(w);
	endfunction

	function automatic int slot_ago(input int age);
		return (slot_next + HIST_SLOTS - age) % HIST_SLOTS;
	endfunction

	// Load a new window and wipe history and sums.
	function automatic void set_window(input logic [rsi_pkg::CFG_W-1:0] w);
		win_len = clamp_window(w);
		up_total = '0;
		down_total = '0;
		seen_cnt = 0;
		slot_next = 0;
	endfunction

	// Fold one price into the window and queue the RSI it must produce.
	function automatic void absorb_price(input logic [31:0] p);
		logic [31:0] prev;
		logic [31:0] newer;
		logic [31:0] older;
		logic [63:0] total;
		rsi_beat_t want;
		if (seen_cnt >= 1) begin
			prev = hist_mem[slot_ago(1)];
			if (p > prev)
				up_total += p - prev;
			else
				down_total += prev - p;
		end
		// drop the move that leaves the window
		if (seen_cnt >= win_len + 1) begin
			newer = hist_mem[slot_ago(win_len)];
			older = hist_mem[slot_ago(win_len + 1)];
			if (newer > older)
				up_total -= newer - older;
			else
				down_total -= older - newer;
		end
		hist_mem[slot_next] = p;
		slot_next = (slot_next + 1) % HIST_SLOTS;
		if (seen_cnt < win_len + 1)
			seen_cnt++;
		total = 64'(up_total) + 64'(down_total);
		if (seen_cnt < win_len + 1) begin
			want.rsi = rsi_pkg::RSI_NEUTRAL;
			want.warm = 1'b1;
			n_warm++;
		end else if (total == 0) begin
			want.rsi = rsi_pkg::RSI_NEUTRAL;
			want.warm = 1'b0;
			n_flat++;
		end else begin
			want.rsi = rsi_pkg::QUO_W'((64'(up_total) * 64'(rsi_pkg::RSI_SCALE)) / total);
			want.warm = 1'b0;
			n_ratio++;
		end
		rsi_due.push_back(want);
	endfunction

	task automatic push_price(input logic [31:0] p);
		stim_beat_t b;
		b.is_cfg = 1'b0;
		b.win = '0;
		b.px = p;
		stim_q.push_back(b);
	endtask

	task automatic push_window(input logic [rsi_pkg::CFG_W-1:0] w);
		stim_beat_t b;
		b.is_cfg = 1'b1;
		b.win = w;
		b.px = '0;
		stim_q.push_back(b);
	endtask

	// Driver: offer queued beats, write the window only once the block drains.
	always @(posedge clk) begin
		stim_beat_t head;
		logic nxt_valid;
		logic nxt_we;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				absorb_price(stim_q[0].px);
				void'(stim_q.pop_front());
				prices_in++;
			end
			nxt_valid = in_valid && in_stall;
			nxt_we = 1'b0;
			if (!nxt_valid && stim_q.size() > 0) begin
				head = stim_q[0];
				if (head.is_cfg) begin
					if (!in_valid && !cfg_we && rsi_due.size() == 0)
						settle++;
					else
						settle = 0;
					if (settle >= SETTLE_CYCLES) begin
						nxt_we = 1'b1;
						cfg_wdata <= head.win;
						set_window(head.win);
						void'(stim_q.pop_front());
						n_writes++;
						settle = 0;
					end
				end else if (steady || $urandom_range(0, 99) >= 10) begin
					nxt_valid = 1'b1;
					price <= head.px;
				end
			end
			in_valid <= nxt_valid;
			cfg_we <= nxt_we;
		end
	end

	// Monitor: check each result beat, stall at random, hold off once for a long stretch.
	always @(posedge clk) begin
		rsi_beat_t want;
		logic nxt_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (rsi_due.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					want = rsi_due.pop_front();
					if (rsi_hundredths !== want.rsi)
						report_mismatch($sformatf("rsi_hundredths %0d, want %0d",
							rsi_hundredths, want.rsi));
					if (warming_up !== want.warm)
						report_mismatch($sformatf("warming_up %b, want %b",
							warming_up, want.warm));
				end
			end
			if (!hold_done && results_seen >= 300) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_stall = 1'b1;
			end else begin
				nxt_stall = !steady && ($urandom_range(0, 99) < 10);
			end
			out_stall <= nxt_stall;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [31:0] last_p;
		logic [rsi_pkg::CFG_W-1:0] w;
		int eff;
		int n_items;
		int pick;
		int up_bias;
		int flat_left;
		int delta;
		int phase;

		// default window: warm-up, full rise, then a full fall
		push_price(32'h0);
		for (int i = 0; i < 14; i++)
			push_price(PRICE_MAX);
		push_price(32'h0);
		// window 0 reads as 1: unchanged price, rise, fall to zero
		push_window('0);
		push_price(32'd5);
		push_price(32'd5);
		push_price(32'd6);
		push_price(32'h0);

		last_p = 32'd1_000_000;
		phase = 0;
		n_items = 20;
		while (n_items < 1750) begin
			case (phase)
				0: w = 7'd127;
				1: w = 7'd64;
				2: w = 7'd65;
				3: w = 7'd1;
				4: w = 7'd2;
				default: w = ($urandom_range(0, 3) == 0) ?
					rsi_pkg::CFG_W'($urandom_range(0, 127)) :
					rsi_pkg::CFG_W'($urandom_range(1, 20));
			endcase
			phase++;
			push_window(w);
			eff = clamp_window(w);
			up_bias = $urandom_range(10, 90);
			flat_left = 0;
			for (int i = eff + 1 + $urandom_range(10, 120); i > 0; i--) begin
				if (flat_left > 0) begin
					flat_left--;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 2) begin
						// long flat run empties both sums
						flat_left = eff + $urandom_range(1, 4);
					end else if (pick < 57) begin
						delta = $urandom_range(0, 2000);
						if ($urandom_range(0, 99) < up_bias)
							last_p = (last_p > PRICE_MAX - delta) ? PRICE_MAX : last_p + delta;
						else
							last_p = (last_p < delta) ? 32'h0 : last_p - delta;
					end else if (pick < 70) begin
						last_p = last_p;
					end else if (pick < 85) begin
						last_p = $urandom();
					end else begin
						last_p = $urandom_range(0, 1) ? PRICE_MAX : 32'h0;
					end
				end
				push_price(last_p);
				n_items++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid || rsi_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d price beats across %0d window writes, incl. 0, 65 and 127",
			prices_in, n_writes);
		$display("results: %0d warming, %0d flat, %0d ratio; %0d mismatches",
			n_warm, n_flat, n_ratio, errors);
		if (errors == 0 && rsi_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Abort a hung run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
